>>> rtl/mfsgd_pkg.sv
// ---------------------------------------------------------------------------
// mfsgd_pkg
// Shared types, widths and constants for the matrix factorisation SGD core.
// ---------------------------------------------------------------------------
package mfsgd_pkg;

   localparam int NUM_USERS   = 4096;
   localparam int NUM_ITEMS   = 4096;
   localparam int NUM_FACTORS = 16;

   localparam int USER_W = 12;
   localparam int ITEM_W = 12;
   localparam int K_W    = (NUM_FACTORS > 1) ? $clog2(NUM_FACTORS) : 1;
   localparam int UF_AW  = $clog2(NUM_USERS * NUM_FACTORS);
   localparam int IF_AW  = $clog2(NUM_ITEMS * NUM_FACTORS);

   localparam int WORD_W  = 32;
   localparam int MEAN_W  = 27;
   localparam int ERR_W   = 28;
   localparam int RATE_W  = 16;
   localparam int OP_W    = 3;
   localparam int SLOT_W  = 5;
   localparam int RTG_W   = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W   = 27;

   localparam int GRAD_W  = 35;
   localparam int T_W     = 36;
   localparam int ACC_W   = 44;
   localparam int MUL_A_W = 36;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   localparam logic [MEAN_W-1:0] RATE_LOW  = MEAN_W'(1 * 16777216);
   localparam logic [MEAN_W-1:0] RATE_HIGH = MEAN_W'(5 * 16777216);

   localparam logic [OP_W-1:0] OP_WRITE_USER = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_ITEM = 3'd1;
   localparam logic [OP_W-1:0] OP_TRAIN      = 3'd2;
   localparam logic [OP_W-1:0] OP_PREDICT    = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_USER  = 3'd4;
   localparam logic [OP_W-1:0] OP_READ_ITEM  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_GLOBAL_MEAN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_RATE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_RATE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_DECAY   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FACTOR_DECAY = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_READ, S_BIAS, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_CLAMP,
      S_FAC_RD, S_FAC_LD, S_LRN_GRAD, S_LRN_DECAY, S_LRN_T, S_LRN_RATE, S_LRN_WB,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      TGT_USER_BIAS, TGT_ITEM_BIAS, TGT_USER_FACTOR, TGT_ITEM_FACTOR
   } target_type;

endpackage

>>> rtl/mfsgd_ram.sv
// ---------------------------------------------------------------------------
// mfsgd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mfsgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mfsgd_mul.sv
// ---------------------------------------------------------------------------
// mfsgd_mul
// Shared signed multiplier with registered product.
// ---------------------------------------------------------------------------
module mfsgd_mul (
   input  logic                                   clock,
   input  logic signed [mfsgd_pkg::MUL_A_W-1:0]   a,
   input  logic signed [mfsgd_pkg::MUL_B_W-1:0]   b,
   output logic signed [mfsgd_pkg::MUL_P_W-1:0]   prod
);
   import mfsgd_pkg::*;

   logic signed [MUL_P_W-1:0] prod_ff;
   logic signed [MUL_P_W-1:0] prod_in;

   always_comb begin
      prod_in = MUL_P_W'(a) * MUL_P_W'(b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> rtl/matrix_factorization_sgd_step_core.sv
// ---------------------------------------------------------------------------
// matrix_factorization_sgd_step_core
// Biased matrix factorisation model store with predict and one-step SGD
// training, sequenced over one shared multiplier.
// ---------------------------------------------------------------------------
// One item at a time: the shared multiplier and the model RAMs (one read and
//   one write a cycle) sequence the work; the next item is taken once the result
//   is registered.
// Reset: synchronous, clears the sequencer, output valid and config registers
//   to their defaults; model RAMs hold no reset value.
// ---------------------------------------------------------------------------
module matrix_factorization_sgd_step_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [mfsgd_pkg::OP_W-1:0]            req_opcode,
   input  logic [mfsgd_pkg::USER_W-1:0]          req_user_index,
   input  logic [mfsgd_pkg::ITEM_W-1:0]          req_item_index,
   input  logic [mfsgd_pkg::SLOT_W-1:0]          req_word_slot,
   input  logic signed [mfsgd_pkg::WORD_W-1:0]   req_write_value,
   input  logic [mfsgd_pkg::RTG_W-1:0]           req_rating,
   input  logic                                  req_item_multi_rated,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mfsgd_pkg::MEAN_W-1:0]          rsp_prediction,
   output logic signed [mfsgd_pkg::ERR_W-1:0]    rsp_error,
   output logic signed [mfsgd_pkg::WORD_W-1:0]   rsp_read_data,
   input  logic                                  csr_write_enable,
   input  logic [mfsgd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfsgd_pkg::CSR_W-1:0]           csr_write_data
);
   import mfsgd_pkg::*;

   state_type state_ff, state_in;

   logic [MEAN_W-1:0] mean_ff;
   logic [RATE_W-1:0] bias_rate_ff, factor_rate_ff, bias_decay_ff, factor_decay_ff;

   logic [OP_W-1:0]          op_ff;
   logic [USER_W-1:0]        user_ff;
   logic [ITEM_W-1:0]        item_ff;
   logic [SLOT_W-1:0]        slot_ff;
   logic signed [WORD_W-1:0] wval_ff;
   logic [RTG_W-1:0]         rating_ff;
   logic                     multi_ff;

   logic [K_W-1:0]           k_ff, k_in;
   target_type               tgt_ff, tgt_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [WORD_W-1:0] ub_ff, ub_in, ib_ff, ib_in, p_ff, p_in, q_ff, q_in;
   logic signed [GRAD_W-1:0] grad_ff, grad_in;
   logic signed [T_W-1:0]    t_ff, t_in;
   logic [MEAN_W-1:0]        pred_ff, pred_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [WORD_W-1:0] rd_ff, rd_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [MEAN_W-1:0]        rsp_pred_ff;
   logic signed [ERR_W-1:0]  rsp_err_ff;
   logic signed [WORD_W-1:0] rsp_rd_ff;

   logic req_take, rsp_load;

   // memory ports
   logic                     ub_we, ib_we, uf_we, if_we;
   logic [WORD_W-1:0]        wr_word;
   logic [WORD_W-1:0]        ub_rd, ib_rd, uf_rd, if_rd;
   logic [UF_AW-1:0]         uf_addr;
   logic [IF_AW-1:0]         if_addr;
   logic [K_W-1:0]           slot_k, word_k;
   logic                     slot_bias, slot_factor, is_access;

   // multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic signed [MUL_P_W-1:0] prod_sh16, prod_sh24;

   logic signed [WORD_W-1:0]   lrn_w, lrn_other, new_w;
   logic signed [WORD_W+4:0]   lrn_sum;
   logic signed [ACC_W-1:0]    acc_bias;
   logic signed [ERR_W-1:0]    rating_q;
   logic [SLOT_W-1:0]          slot_m1;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // ---------------- decode of the access slot
   assign slot_m1     = slot_ff - SLOT_W'(1);
   assign slot_k      = slot_m1[K_W-1:0];
   assign slot_bias   = (slot_ff == '0);
   assign slot_factor = (slot_ff != '0) && (32'(slot_ff) <= NUM_FACTORS);
   assign is_access   = (op_ff == OP_WRITE_USER) || (op_ff == OP_WRITE_ITEM) ||
                        (op_ff == OP_READ_USER) || (op_ff == OP_READ_ITEM);
   assign word_k      = is_access ? slot_k : k_ff;
   assign uf_addr     = UF_AW'(user_ff) * UF_AW'(NUM_FACTORS) + UF_AW'(word_k);
   assign if_addr     = IF_AW'(item_ff) * IF_AW'(NUM_FACTORS) + IF_AW'(word_k);

   // ---------------- learn operands
   always_comb begin
      case (tgt_ff)
         TGT_USER_BIAS:   lrn_w = ub_ff;
         TGT_ITEM_BIAS:   lrn_w = ib_ff;
         TGT_USER_FACTOR: lrn_w = p_ff;
         default:         lrn_w = q_ff;
      endcase
      lrn_other = (tgt_ff == TGT_USER_FACTOR) ? q_ff : p_ff;
   end

   assign prod_sh16 = prod >>> 16;
   assign prod_sh24 = prod >>> 24;
   assign lrn_sum   = (WORD_W+5)'(lrn_w) + prod_sh16[WORD_W+4:0];

   always_comb begin
      if (lrn_sum > (WORD_W+5)'(32'sh7FFFFFFF)) begin
         new_w = 32'sh7FFFFFFF;
      end else if (lrn_sum < -(WORD_W+5)'(64'sh80000000)) begin
         new_w = 32'sh80000000;
      end else begin
         new_w = lrn_sum[WORD_W-1:0];
      end
   end

   assign acc_bias = ACC_W'($signed({1'b0, mean_ff})) + ACC_W'($signed(ub_rd)) +
                     ACC_W'($signed(ib_rd));
   assign rating_q = $signed({1'b0, rating_ff, 24'b0});

   // ---------------- multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DOT_MUL: begin
            mul_a = MUL_A_W'($signed(uf_rd));
            mul_b = $signed(if_rd);
         end
         S_LRN_GRAD: begin
            mul_a = MUL_A_W'(err_ff);
            mul_b = lrn_other;
         end
         S_LRN_DECAY: begin
            mul_a = MUL_A_W'(lrn_w);
            mul_b = (tgt_ff == TGT_USER_BIAS || tgt_ff == TGT_ITEM_BIAS) ?
                    $signed(MUL_B_W'(bias_decay_ff)) : $signed(MUL_B_W'(factor_decay_ff));
         end
         S_LRN_RATE: begin
            mul_a = t_ff;
            mul_b = (tgt_ff == TGT_USER_BIAS || tgt_ff == TGT_ITEM_BIAS) ?
                    $signed(MUL_B_W'(bias_rate_ff)) : $signed(MUL_B_W'(factor_rate_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   mfsgd_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // ---------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (req_take) state_in = S_START;
         S_START: begin
            case (op_ff) inside
               OP_WRITE_USER, OP_WRITE_ITEM: state_in = S_DONE;
               OP_READ_USER, OP_READ_ITEM:   state_in = S_READ;
               OP_TRAIN, OP_PREDICT:         state_in = S_BIAS;
               default:                      state_in = S_DONE;
            endcase
         end
         S_READ:      state_in = S_DONE;
         S_BIAS:      state_in = multi_ff ? S_DOT_RD : S_CLAMP;
         S_DOT_RD:    state_in = S_DOT_MUL;
         S_DOT_MUL:   state_in = S_DOT_ACC;
         S_DOT_ACC:   state_in = (32'(k_ff) == NUM_FACTORS - 1) ? S_CLAMP : S_DOT_RD;
         S_CLAMP:     state_in = (op_ff == OP_TRAIN) ? S_LRN_DECAY : S_DONE;
         S_FAC_RD:    state_in = S_FAC_LD;
         S_FAC_LD:    state_in = S_LRN_GRAD;
         S_LRN_GRAD:  state_in = S_LRN_DECAY;
         S_LRN_DECAY: state_in = S_LRN_T;
         S_LRN_T:     state_in = S_LRN_RATE;
         S_LRN_RATE:  state_in = S_LRN_WB;
         S_LRN_WB: begin
            case (tgt_ff)
               TGT_USER_BIAS:   state_in = S_LRN_DECAY;
               TGT_ITEM_BIAS:   state_in = S_FAC_RD;
               TGT_USER_FACTOR: state_in = S_LRN_GRAD;
               default: state_in = (32'(k_ff) == NUM_FACTORS - 1) ? S_DONE : S_FAC_RD;
            endcase
         end
         S_DONE:      if (rsp_load) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // ---------------- datapath and outputs
   always_comb begin
      k_in     = k_ff;
      tgt_in   = tgt_ff;
      acc_in   = acc_ff;
      ub_in    = ub_ff;
      ib_in    = ib_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      grad_in  = grad_ff;
      t_in     = t_ff;
      pred_in  = pred_ff;
      err_in   = err_ff;
      rd_in    = rd_ff;
      ub_we    = 1'b0;
      ib_we    = 1'b0;
      uf_we    = 1'b0;
      if_we    = 1'b0;
      wr_word  = new_w;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pred_in = '0;
               err_in  = '0;
               rd_in   = '0;
            end
         end
         S_START: begin
            wr_word = wval_ff;
            if (op_ff == OP_WRITE_USER) begin
               ub_we = slot_bias;
               uf_we = slot_factor;
            end else if (op_ff == OP_WRITE_ITEM) begin
               ib_we = slot_bias;
               if_we = slot_factor;
            end
         end
         S_READ: begin
            if (op_ff == OP_READ_USER) begin
               rd_in = slot_bias ? ub_rd : (slot_factor ? uf_rd : '0);
            end else begin
               rd_in = slot_bias ? ib_rd : (slot_factor ? if_rd : '0);
            end
         end
         S_BIAS: begin
            ub_in  = ub_rd;
            ib_in  = ib_rd;
            acc_in = acc_bias;
            k_in   = '0;
         end
         S_DOT_ACC: begin
            acc_in = acc_ff + prod_sh24[ACC_W-1:0];
            k_in   = k_ff + K_W'(1);
         end
         S_CLAMP: begin
            if (acc_ff < ACC_W'($signed({1'b0, RATE_LOW}))) begin
               pred_in = RATE_LOW;
            end else if (acc_ff > ACC_W'($signed({1'b0, RATE_HIGH}))) begin
               pred_in = RATE_HIGH;
            end else begin
               pred_in = acc_ff[MEAN_W-1:0];
            end
            if (op_ff == OP_TRAIN) begin
               err_in  = rating_q - $signed({1'b0, pred_in});
               grad_in = GRAD_W'(err_in);
               tgt_in  = TGT_USER_BIAS;
            end
         end
         S_FAC_LD: begin
            p_in   = uf_rd;
            q_in   = if_rd;
            tgt_in = TGT_USER_FACTOR;
         end
         S_LRN_DECAY: begin
            // factor gradient is err * other, back to Q8.24
            if (tgt_ff == TGT_USER_FACTOR || tgt_ff == TGT_ITEM_FACTOR) begin
               grad_in = prod_sh24[GRAD_W-1:0];
            end
         end
         S_LRN_T: begin
            t_in = T_W'(grad_ff) - prod_sh16[T_W-1:0];
         end
         S_LRN_WB: begin
            case (tgt_ff)
               TGT_USER_BIAS: begin
                  ub_we   = 1'b1;
                  grad_in = GRAD_W'(err_ff);
                  tgt_in  = TGT_ITEM_BIAS;
               end
               TGT_ITEM_BIAS: begin
                  ib_we = 1'b1;
                  k_in  = '0;
               end
               TGT_USER_FACTOR: begin
                  uf_we  = 1'b1;
                  p_in   = new_w;
                  tgt_in = TGT_ITEM_FACTOR;
               end
               default: begin
                  if_we = 1'b1;
                  q_in  = new_w;
                  k_in  = k_ff + K_W'(1);
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         mean_ff         <= MEAN_W'(50331648);
         bias_rate_ff    <= RATE_W'(524);
         factor_rate_ff  <= RATE_W'(524);
         bias_decay_ff   <= RATE_W'(655);
         factor_decay_ff <= RATE_W'(655);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_GLOBAL_MEAN:  mean_ff         <= csr_write_data;
               CSR_BIAS_RATE:    bias_rate_ff    <= csr_write_data[RATE_W-1:0];
               CSR_FACTOR_RATE:  factor_rate_ff  <= csr_write_data[RATE_W-1:0];
               CSR_BIAS_DECAY:   bias_decay_ff   <= csr_write_data[RATE_W-1:0];
               CSR_FACTOR_DECAY: factor_decay_ff <= csr_write_data[RATE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_opcode;
         user_ff   <= req_user_index;
         item_ff   <= req_item_index;
         slot_ff   <= req_word_slot;
         wval_ff   <= req_write_value;
         rating_ff <= req_rating;
         multi_ff  <= req_item_multi_rated;
      end
      k_ff    <= k_in;
      tgt_ff  <= tgt_in;
      acc_ff  <= acc_in;
      ub_ff   <= ub_in;
      ib_ff   <= ib_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      grad_ff <= grad_in;
      t_ff    <= t_in;
      pred_ff <= pred_in;
      err_ff  <= err_in;
      rd_ff   <= rd_in;
      if (rsp_load) begin
         rsp_pred_ff <= pred_ff;
         rsp_err_ff  <= err_ff;
         rsp_rd_ff   <= rd_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_pred_ff;
   assign rsp_error      = rsp_err_ff;
   assign rsp_read_data  = rsp_rd_ff;

   // ---------------- model stores
   mfsgd_ram #(.WIDTH(WORD_W), .DEPTH(NUM_USERS)) u_user_bias (
      .clock   (clock),
      .wr_en   (ub_we),
      .wr_addr (user_ff),
      .wr_data (wr_word),
      .rd_addr (user_ff),
      .rd_data (ub_rd)
   );

   mfsgd_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ITEMS)) u_item_bias (
      .clock   (clock),
      .wr_en   (ib_we),
      .wr_addr (item_ff),
      .wr_data (wr_word),
      .rd_addr (item_ff),
      .rd_data (ib_rd)
   );

   mfsgd_ram #(.WIDTH(WORD_W), .DEPTH(NUM_USERS * NUM_FACTORS)) u_user_factors (
      .clock   (clock),
      .wr_en   (uf_we),
      .wr_addr (uf_addr),
      .wr_data (wr_word),
      .rd_addr (uf_addr),
      .rd_data (uf_rd)
   );

   mfsgd_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ITEMS * NUM_FACTORS)) u_item_factors (
      .clock   (clock),
      .wr_en   (if_we),
      .wr_addr (if_addr),
      .wr_data (wr_word),
      .rd_addr (if_addr),
      .rd_data (if_rd)
   );

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking regression for matrix_factorization_sgd_step_core: a shadow
// model of the bias and factor store predicts each response, with random
// traffic, idling on both sides and several learning-rate settings.
// ---------------------------------------------------------------------------
module tb;
   import mfsgd_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd6;
   localparam longint ONE_Q24 = 64'sd16777216;
   localparam int POOL_N = 8;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_LEN = 400;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [USER_W-1:0] user;
      logic [ITEM_W-1:0] item;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] value;
      logic [RTG_W-1:0]  rating;
      logic              multi;
   } rating_req_type;

   typedef struct {
      logic [MEAN_W-1:0] pred;
      logic [ERR_W-1:0]  err;
      logic [WORD_W-1:0] rdata;
   } rating_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OP_W-1:0] req_opcode = '0;
   logic [USER_W-1:0] req_user_index = '0;
   logic [ITEM_W-1:0] req_item_index = '0;
   logic [SLOT_W-1:0] req_word_slot = '0;
   logic signed [WORD_W-1:0] req_write_value = '0;
   logic [RTG_W-1:0] req_rating = '0;
   logic req_item_multi_rated = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [MEAN_W-1:0] rsp_prediction;
   logic signed [ERR_W-1:0] rsp_error;
   logic signed [WORD_W-1:0] rsp_read_data;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_write_data = '0;

   matrix_factorization_sgd_step_core u_dut (.*);

   // shadow copy of the model and its settings
   logic signed [WORD_W-1:0] user_bias_m[int];
   logic signed [WORD_W-1:0] item_bias_m[int];
   logic signed [WORD_W-1:0] user_fac_m[int];
   logic signed [WORD_W-1:0] item_fac_m[int];
   logic [MEAN_W-1:0] mean_m = 27'd50331648;
   logic [RATE_W-1:0] brate_m = 16'd524, frate_m = 16'd524;
   logic [RATE_W-1:0] bdecay_m = 16'd655, fdecay_m = 16'd655;

   rating_req_type pending_items[$];
   rating_rsp_type expected_rsps[$];
   int user_pool[POOL_N];
   int item_pool[POOL_N];
   int failures = 0, checked = 0, n_train = 0, n_predict = 0, n_access = 0;
   bit quiet = 0, hold_go = 0;
   int hold_count = 0;
   int req_gap = 0, rsp_gap = 0;
   longint cycles = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic signed [WORD_W-1:0] sat_word(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] sgd_update(input logic signed [WORD_W-1:0] w,
         input longint grad, input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] decay);
      longint t;
      t = grad - ((longint'(decay) * longint'(w)) >>> 16);
      return sat_word(longint'(w) + ((longint'(rate) * t) >>> 16));
   endfunction

   function automatic logic signed [WORD_W-1:0] fetch(ref logic signed [WORD_W-1:0] m[int],
         input int key);
      return m.exists(key) ? m[key] : '0;
   endfunction

   // applies one item to the shadow model and returns the response it should give
   function automatic rating_rsp_type model_step(input rating_req_type r);
      rating_rsp_type o;
      int u, it, key;
      longint acc, err;
      logic signed [WORD_W-1:0] p, q;
      bit user_side;
      o.pred = '0;
      o.err = '0;
      o.rdata = '0;
      u = int'(r.user);
      it = int'(r.item);
      case (r.op) inside
         OP_WRITE_USER, OP_WRITE_ITEM, OP_READ_USER, OP_READ_ITEM: begin
            user_side = (r.op == OP_WRITE_USER || r.op == OP_READ_USER);
            if (r.slot <= NUM_FACTORS) begin
               key = (r.slot == 0) ? (user_side ? u : it)
                                   : (user_side ? u : it) * NUM_FACTORS + r.slot - 1;
               if (r.op == OP_WRITE_USER || r.op == OP_WRITE_ITEM) begin
                  if (r.slot == 0 && user_side) user_bias_m[key] = r.value;
                  else if (r.slot == 0) item_bias_m[key] = r.value;
                  else if (user_side) user_fac_m[key] = r.value;
                  else item_fac_m[key] = r.value;
               end else begin
                  if (r.slot == 0 && user_side) o.rdata = fetch(user_bias_m, key);
                  else if (r.slot == 0) o.rdata = fetch(item_bias_m, key);
                  else if (user_side) o.rdata = fetch(user_fac_m, key);
                  else o.rdata = fetch(item_fac_m, key);
               end
            end
         end
         OP_TRAIN, OP_PREDICT: begin
            acc = longint'(mean_m) + longint'(fetch(user_bias_m, u))
                  + longint'(fetch(item_bias_m, it));
            if (r.multi)
               for (int k = 0; k < NUM_FACTORS; k++)
                  acc += (longint'(fetch(user_fac_m, u*NUM_FACTORS+k))
                          * longint'(fetch(item_fac_m, it*NUM_FACTORS+k))) >>> 24;
            if (acc < ONE_Q24) acc = ONE_Q24;
            if (acc > 5*ONE_Q24) acc = 5*ONE_Q24;
            o.pred = acc[MEAN_W-1:0];
            if (r.op == OP_TRAIN) begin
               err = longint'(r.rating) * ONE_Q24 - acc;
               o.err = err[ERR_W-1:0];
               user_bias_m[u] = sgd_update(fetch(user_bias_m, u), err, brate_m, bdecay_m);
               item_bias_m[it] = sgd_update(fetch(item_bias_m, it), err, brate_m, bdecay_m);
               for (int k = 0; k < NUM_FACTORS; k++) begin
                  p = fetch(user_fac_m, u*NUM_FACTORS+k);
                  q = fetch(item_fac_m, it*NUM_FACTORS+k);
                  p = sgd_update(p, (err * longint'(q)) >>> 24, frate_m, fdecay_m);
                  // item factor learns from the freshly updated user factor
                  q = sgd_update(q, (err * longint'(p)) >>> 24, frate_m, fdecay_m);
                  user_fac_m[u*NUM_FACTORS+k] = p;
                  item_fac_m[it*NUM_FACTORS+k] = q;
               end
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(posedge clock) begin
      rating_req_type nxt;
      bit take_next;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            nxt.op = req_opcode;
            nxt.user = req_user_index;
            nxt.item = req_item_index;
            nxt.slot = req_word_slot;
            nxt.value = req_write_value;
            nxt.rating = req_rating;
            nxt.multi = req_item_multi_rated;
            expected_rsps.push_back(model_step(nxt));
            if (nxt.op == OP_TRAIN) n_train++;
            else if (nxt.op == OP_PREDICT) n_predict++;
            else n_access++;
         end
         if (!req_valid || !req_stall) begin
            take_next = 0;
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_items.size() != 0) begin
               if (!quiet && $urandom_range(0, 9) == 0) req_gap = $urandom_range(0, 6);
               else take_next = 1;
            end
            if (take_next) begin
               nxt = pending_items.pop_front();
               req_opcode <= nxt.op;
               req_user_index <= nxt.user;
               req_item_index <= nxt.item;
               req_word_slot <= nxt.slot;
               req_write_value <= nxt.value;
               req_rating <= nxt.rating;
               req_item_multi_rated <= nxt.multi;
            end
            req_valid <= take_next;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_go && hold_count < HOLD_LEN) hold_count <= hold_count + 1;
   end

   // monitor
   always @(posedge clock) begin
      rating_rsp_type e;
      bit stall_nxt;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("matrix_factorization_sgd_step_core regression: fail");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("response with nothing expected");
            failures++;
         end else begin
            e = expected_rsps.pop_front();
            checked++;
            if (rsp_prediction !== e.pred) begin
               $error("prediction: expected %0d actual %0d", e.pred, rsp_prediction);
               failures++;
            end
            if (rsp_error !== e.err) begin
               $error("error: expected %0d actual %0d", $signed(e.err), rsp_error);
               failures++;
            end
            if (rsp_read_data !== e.rdata) begin
               $error("read_data: expected %0d actual %0d", $signed(e.rdata), rsp_read_data);
               failures++;
            end
         end
      end
      stall_nxt = 0;
      if (hold_go && hold_count < HOLD_LEN) begin
         stall_nxt = 1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         stall_nxt = 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 6);
         stall_nxt = 1;
      end
      rsp_stall <= reset ? 1'b0 : stall_nxt;
   end

   task automatic add_item(input logic [OP_W-1:0] op, input int u, input int it,
         input int slot, input logic [WORD_W-1:0] val, input int rtg, input bit multi);
      rating_req_type r;
      r.op = op;
      r.user = USER_W'(u);
      r.item = ITEM_W'(it);
      r.slot = SLOT_W'(slot);
      r.value = val;
      r.rating = RTG_W'(rtg);
      r.multi = multi;
      pending_items.push_back(r);
   endtask

   // mostly modest weights, now and then anything at all
   function automatic logic [WORD_W-1:0] model_word();
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= CSR_W'(val);
      case (idx)
         CSR_GLOBAL_MEAN:  mean_m = MEAN_W'(val);
         CSR_BIAS_RATE:    brate_m = RATE_W'(val);
         CSR_FACTOR_RATE:  frate_m = RATE_W'(val);
         CSR_BIAS_DECAY:   bdecay_m = RATE_W'(val);
         CSR_FACTOR_DECAY: fdecay_m = RATE_W'(val);
         default: ;
      endcase
   endtask

   task automatic set_rates(input int mean, input int br, input int fr, input int bd,
         input int fd);
      csr_write(CSR_GLOBAL_MEAN, mean);
      csr_write(CSR_BIAS_RATE, br);
      csr_write(CSR_FACTOR_RATE, fr);
      csr_write(CSR_BIAS_DECAY, bd);
      csr_write(CSR_FACTOR_DECAY, fd);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || expected_rsps.size() != 0 || req_valid)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic random_items(input int n);
      int pick, u, it;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         u = user_pool[$urandom_range(0, POOL_N-1)];
         it = item_pool[$urandom_range(0, POOL_N-1)];
         if (pick < 45)
            add_item(OP_TRAIN, u, it, $urandom_range(0, 31), $urandom,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5),
                     $urandom_range(0, 3) != 0);
         else if (pick < 65)
            add_item(OP_PREDICT, u, it, $urandom_range(0, 31), $urandom, $urandom_range(0, 7),
                     $urandom_range(0, 1));
         else if (pick < 75)
            add_item($urandom_range(0, 1) ? OP_WRITE_USER : OP_WRITE_ITEM, u, it,
                     $urandom_range(0, NUM_FACTORS), model_word(), $urandom_range(0, 7),
                     $urandom_range(0, 1));
         else if (pick < 85)
            add_item($urandom_range(0, 1) ? OP_READ_USER : OP_READ_ITEM, u, it,
                     $urandom_range(0, NUM_FACTORS), $urandom, $urandom_range(0, 7),
                     $urandom_range(0, 1));
         else if (pick < 90)
            // writes anywhere are safe; out-of-range slots are dropped
            add_item($urandom_range(0, 1) ? OP_WRITE_USER : OP_WRITE_ITEM,
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(NUM_FACTORS + 1, 31), $urandom, $urandom_range(0, 7),
                     $urandom_range(0, 1));
         else if (pick < 95)
            add_item($urandom_range(0, 1) ? OP_READ_USER : OP_READ_ITEM,
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(NUM_FACTORS + 1, 31), $urandom, $urandom_range(0, 7),
                     $urandom_range(0, 1));
         else
            add_item($urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B,
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 31), $urandom, $urandom_range(0, 7),
                     $urandom_range(0, 1));
      end
   endtask

   initial begin
      user_pool[0] = 0;
      user_pool[1] = 4095;
      item_pool[0] = 0;
      item_pool[1] = 4095;
      for (int i = 2; i < POOL_N; i++) begin
         user_pool[i] = $urandom_range(1, 4094);
         item_pool[i] = $urandom_range(1, 4094);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // every word the pool can touch is written before any read
      for (int i = 0; i < POOL_N; i++)
         for (int s = 0; s <= NUM_FACTORS; s++) begin
            add_item(OP_WRITE_USER, user_pool[i], 0, s, model_word(), 0, 0);
            add_item(OP_WRITE_ITEM, 0, item_pool[i], s, model_word(), 0, 0);
         end

      // extremes and corner cases
      add_item(OP_WRITE_USER, 4095, 0, 0, 32'h7fffffff, 0, 0);
      add_item(OP_READ_USER, 4095, 0, 0, 0, 0, 0);
      add_item(OP_WRITE_ITEM, 0, 4095, NUM_FACTORS, 32'h80000000, 0, 0);
      add_item(OP_READ_ITEM, 0, 4095, NUM_FACTORS, 0, 0, 0);
      add_item(OP_PREDICT, 4095, 0, 0, 0, 0, 1);
      add_item(OP_WRITE_ITEM, 0, 0, 0, 32'h80000000, 0, 0);
      add_item(OP_PREDICT, 0, 0, 0, 0, 0, 0);
      add_item(OP_TRAIN, 0, 4095, 0, 0, 5, 1);
      add_item(OP_TRAIN, 4095, 4095, 0, 0, 0, 1);
      add_item(OP_TRAIN, 4095, 0, 0, 0, 7, 0);
      add_item(OP_TRAIN, 0, 0, 0, 0, 1, 1);
      add_item(OP_WRITE_USER, 4095, 4095, 31, 32'hffffffff, 7, 1);
      add_item(OP_WRITE_ITEM, 0, 0, NUM_FACTORS + 1, 32'h12345678, 0, 0);
      add_item(OP_READ_USER, 2049, 0, NUM_FACTORS + 1, 0, 0, 0);
      add_item(OP_READ_ITEM, 0, 4095, 31, 0, 0, 0);
      add_item(OP_SPARE_A, 4095, 4095, 31, 32'hffffffff, 7, 1);
      add_item(OP_SPARE_B, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < POOL_N; i++) begin
         add_item(OP_WRITE_USER, user_pool[i], 0, 0, model_word(), 0, 0);
         add_item(OP_WRITE_ITEM, 0, item_pool[i], 0, model_word(), 0, 0);
      end
      add_item(OP_WRITE_ITEM, 0, 4095, NUM_FACTORS, model_word(), 0, 0);
      drain();

      random_items(200);
      drain();

      set_rates(16777216, 0, 0, 0, 0);
      csr_write(CSR_UNUSED, 27'h7ffffff);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      hold_go = 1;
      random_items(200);
      drain();

      set_rates(83886080, 65535, 65535, 65535, 65535);
      random_items(180);
      drain();

      set_rates($urandom_range(16777216, 83886080), $urandom_range(0, 65535),
                $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom_range(0, 65535));
      random_items(180);
      drain();

      set_rates(50331648, 524, 524, 655, 655);
      quiet = 1;
      random_items(120);
      drain();

      $display("covered %0d trains, %0d predicts, %0d access/other items; %0d responses checked",
               n_train, n_predict, n_access, checked);
      $display("over five rate settings including zero and full-scale learning");
      if (failures == 0 && expected_rsps.size() == 0) begin
         $display("matrix_factorization_sgd_step_core regression: pass");
      end else begin
         $display("matrix_factorization_sgd_step_core regression: fail");
      end
      $finish;
   end

endmodule
